// File: rtl/dteq_pkg.sv
// Package with shared types, constants and codes of the timer event queue.
`timescale 1ns / 1ps
`default_nettype none
package dteq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam logic [15:0] TICK_PERIOD_RST = 16'd1000;
  localparam int TIME_W = 48;
  localparam int ID_W = 31;
  localparam int TAG_W = 32;
  localparam int DELAY_W = 32;

  // Command codes.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_DEL   = 3'd2;
  localparam logic [2:0] CMD_SET   = 3'd3;
  localparam logic [2:0] CMD_UNSET = 3'd4;

  // Result kind codes.
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_DEL  = 3'd1;
  localparam logic [2:0] KIND_EVT  = 3'd2;
  localparam logic [2:0] KIND_SLOT = 3'd3;
  localparam logic [2:0] KIND_DONE = 3'd4;

  typedef struct packed {
    logic [2:0]         command;
    logic [DELAY_W-1:0] delay_us;
    logic [TAG_W-1:0]   event_tag;
    logic [ID_W-1:0]    event_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [ID_W-1:0]  result_id;
    logic [TAG_W-1:0] result_tag;
    logic             ok;
    logic             last;
  } out_word_t;

  // One table entry as stored in memory.
  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   ident;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture input word
    logic adv_time;     // now += period
    logic clr_idx;      // index = 0
    logic inc_idx;      // index++
    logic dec_idx;      // index--
    logic set_idx_cnt;  // index = count
    logic rd_idx;       // read entry at index
    logic rd_idx_p1;    // read entry at index+1
    logic rd_idx_m1;    // read entry at index-1
    logic wr_hold;      // write held entry at index
    logic wr_new;       // write new entry at index
    logic cnt_inc;
    logic cnt_dec;
    logic id_inc;
    logic slot_set;
    logic slot_clr;
    logic emit;
    logic [2:0] emit_kind;
    logic emit_ok;
    logic emit_last;
    logic emit_entry;   // take id/tag from read entry
    logic emit_slot;    // take tag from slot
    logic emit_newid;   // take id from next id
    logic emit_reqid;   // take id from request
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] command;
    logic       idx_lt_cnt;   // index < count
    logic       idx_zero;
    logic       cnt_full;
    logic       cnt_zero;
    logic       rd_expired;   // read deadline <= now
    logic       rd_le_new;    // read deadline <= new deadline
    logic       rd_id_match;
    logic       slot_fire;
    logic       idx_p1_lt_cnt;
  } ctl_sts_t;

endpackage
`default_nettype wire

// File: rtl/dteq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dteq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/dteq_datapath.sv
// Datapath of the timer event queue: time, table memory, slot and result register.
`timescale 1ns / 1ps
`default_nettype none
module dteq_datapath
  import dteq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  in_word_t       in_word,
  input  ctl_cmd_t       cmd,
  output ctl_sts_t       sts,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]       period_r;
  logic [TIME_W-1:0] now_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     idx_r;
  logic [ID_W-1:0]   next_id_r;
  logic [TIME_W-1:0] slot_dl_r;
  logic [TAG_W-1:0]  slot_tag_r;
  logic              slot_armed_r;
  in_word_t          req_r;
  entry_t            hold_r;
  logic              rd_pend_r;
  logic              out_valid_r;
  out_word_t         out_r;

  logic [TIME_W-1:0] new_dl;
  entry_t            rd_ent;
  entry_t            wr_ent;
  logic [CW-1:0]     raddr_full;
  logic              we;

  assign new_dl = now_r + {{(TIME_W-DELAY_W){1'b0}}, req_r.delay_us};

  // Read address select.
  always_comb begin
    raddr_full = idx_r;
    if (cmd.rd_idx_p1) begin
      raddr_full = idx_r + CW'(1);
    end else if (cmd.rd_idx_m1) begin
      raddr_full = idx_r - CW'(1);
    end
  end

  // Write data: the shifted entry or the newly added one.
  always_comb begin
    wr_ent = hold_r;
    if (cmd.wr_new) begin
      wr_ent.deadline = new_dl;
      wr_ent.tag      = req_r.event_tag;
      wr_ent.ident    = next_id_r;
    end
  end
  assign we = cmd.wr_hold | cmd.wr_new;

  dteq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_tab (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r[AW-1:0]),
    .wdata (wr_ent),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rd_ent)
  );

  // Status toward the controller.
  always_comb begin
    sts.command       = req_r.command;
    sts.idx_lt_cnt    = idx_r < cnt_r;
    sts.idx_p1_lt_cnt = (idx_r + CW'(1)) < cnt_r;
    sts.idx_zero      = idx_r == '0;
    sts.cnt_full      = cnt_r == CW'(QUEUE_DEPTH);
    sts.cnt_zero      = cnt_r == '0;
    sts.rd_expired    = rd_ent.deadline <= now_r;
    sts.rd_le_new     = rd_ent.deadline <= new_dl;
    sts.rd_id_match   = rd_ent.ident == req_r.event_id;
    sts.slot_fire     = slot_armed_r && (slot_dl_r <= now_r);
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= TICK_PERIOD_RST;
      now_r        <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      next_id_r    <= '0;
      slot_dl_r    <= '0;
      slot_tag_r   <= '0;
      slot_armed_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (cmd.adv_time) begin
        now_r <= now_r + {{(TIME_W-16){1'b0}}, period_r};
      end
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.set_idx_cnt) begin
        idx_r <= cnt_r;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + CW'(1);
      end else if (cmd.dec_idx) begin
        idx_r <= idx_r - CW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.id_inc) begin
        next_id_r <= next_id_r + ID_W'(1);
      end
      if (cmd.slot_set) begin
        slot_dl_r    <= new_dl;
        slot_tag_r   <= req_r.event_tag;
        slot_armed_r <= 1'b1;
      end else if (cmd.slot_clr) begin
        slot_armed_r <= 1'b0;
      end
      rd_pend_r   <= cmd.rd_idx | cmd.rd_idx_p1 | cmd.rd_idx_m1;
      out_valid_r <= cmd.emit;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_word;
    end
    if (rd_pend_r) begin
      hold_r <= rd_ent;
    end
    if (cmd.emit) begin
      out_r.kind       <= cmd.emit_kind;
      out_r.ok         <= cmd.emit_ok;
      out_r.last       <= cmd.emit_last;
      out_r.result_tag <= cmd.emit_entry ? rd_ent.tag :
                          (cmd.emit_slot ? slot_tag_r : '0);
      out_r.result_id  <= cmd.emit_entry ? rd_ent.ident :
                          (cmd.emit_newid ? next_id_r :
                          (cmd.emit_reqid ? req_r.event_id : '0));
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

// File: rtl/dteq_ctrl.sv
// Controller state machine of the timer event queue.
`timescale 1ns / 1ps
`default_nettype none
module dteq_ctrl
  import dteq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  ctl_sts_t  sts,
  output ctl_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_TK_RD    = 13'b0000000000100,
    S_TK_CHK   = 13'b0000000001000,
    S_TK_SHR   = 13'b0000000010000,
    S_TK_SHW   = 13'b0000000100000,
    S_TK_END   = 13'b0000001000000,
    S_AD_RD    = 13'b0000010000000,
    S_AD_CHK   = 13'b0000100000000,
    S_DL_RD    = 13'b0001000000000,
    S_DL_CHK   = 13'b0010000000000,
    S_WAIT     = 13'b0100000000000,
    S_TK_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   del_r, del_nxt; // shift-down pass belongs to a delete
  logic   start_acc;

  assign busy      = state_r != S_IDLE;
  assign start_acc = start && !busy;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    del_nxt   = del_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start_acc) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.command)
          CMD_TICK: begin
            cmd.adv_time = 1'b1;
            cmd.clr_idx  = 1'b1;
            state_nxt    = S_TK_RD;
          end
          CMD_ADD: begin
            if (sts.cnt_full) begin
              cmd.emit       = 1'b1;
              cmd.emit_kind  = KIND_ADD;
              cmd.emit_last  = 1'b1;
              cmd.emit_newid = 1'b1;
              cmd.id_inc     = 1'b1;
              state_nxt      = S_WAIT;
            end else begin
              cmd.set_idx_cnt = 1'b1;
              state_nxt       = S_AD_RD;
            end
          end
          CMD_DEL: begin
            cmd.clr_idx = 1'b1;
            state_nxt   = S_DL_RD;
          end
          CMD_SET, CMD_UNSET: begin
            cmd.slot_set  = sts.command == CMD_SET;
            cmd.slot_clr  = sts.command == CMD_UNSET;
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            cmd.emit_ok   = 1'b1;
            cmd.emit_last = 1'b1;
            state_nxt     = S_WAIT;
          end
          default: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            cmd.emit_last = 1'b1;
            state_nxt     = S_WAIT;
          end
        endcase
      end
      // Tick: look at the head entry.
      S_TK_RD: begin
        if (sts.cnt_zero) begin
          state_nxt = S_TK_END;
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        if (sts.rd_expired) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_EVT;
          cmd.emit_ok    = 1'b1;
          cmd.emit_entry = 1'b1;
          del_nxt        = 1'b0;
          state_nxt      = S_TK_SHR;
        end else begin
          state_nxt = S_TK_END;
        end
      end
      // Shift entries above the index down by one.
      S_TK_SHR: begin
        if (sts.idx_p1_lt_cnt) begin
          cmd.rd_idx_p1 = 1'b1;
          state_nxt     = S_TK_SHW;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = del_r ? S_WAIT : S_TK_RD;
          if (del_r) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = KIND_DEL;
            cmd.emit_ok    = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_reqid = 1'b1;
          end
        end
      end
      S_TK_SHW: begin
        state_nxt = S_TK_DONE;
      end
      S_TK_DONE: begin
        cmd.wr_hold = 1'b1;
        cmd.inc_idx = 1'b1;
        state_nxt   = S_TK_SHR;
      end
      S_TK_END: begin
        cmd.emit      = 1'b1;
        cmd.emit_ok   = 1'b1;
        if (sts.slot_fire) begin
          cmd.slot_clr  = 1'b1;
          cmd.emit_kind = KIND_SLOT;
          cmd.emit_slot = 1'b1;
        end else begin
          cmd.emit_kind = KIND_DONE;
          cmd.emit_last = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      // Add: walk down from the top, shifting larger deadlines up.
      S_AD_RD: begin
        if (sts.idx_zero) begin
          cmd.wr_new     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.id_inc     = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_ADD;
          cmd.emit_ok    = 1'b1;
          cmd.emit_last  = 1'b1;
          cmd.emit_newid = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          cmd.rd_idx_m1 = 1'b1;
          state_nxt     = S_AD_CHK;
        end
      end
      S_AD_CHK: begin
        if (sts.rd_le_new) begin
          cmd.wr_new     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.id_inc     = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_ADD;
          cmd.emit_ok    = 1'b1;
          cmd.emit_last  = 1'b1;
          cmd.emit_newid = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          // hold_r takes the read entry this cycle; write it one slot up next.
          state_nxt = S_TK_SHW;
          del_nxt   = 1'b1;
        end
      end
      // Delete: linear search by id.
      S_DL_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_DL_CHK;
        end else begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = KIND_DEL;
          cmd.emit_last  = 1'b1;
          cmd.emit_reqid = 1'b1;
          state_nxt      = S_WAIT;
        end
      end
      S_DL_CHK: begin
        if (sts.rd_id_match) begin
          del_nxt   = 1'b1;
          state_nxt = S_TK_SHR;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_DL_RD;
        end
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // The add path reuses the shift states: redirect them.
    if (state_r == S_TK_SHW && sts.command == CMD_ADD) begin
      cmd.wr_hold = 1'b0;
      state_nxt   = S_AD_RD;
    end
    if (state_r == S_TK_DONE && sts.command == CMD_ADD) begin
      cmd.wr_hold = 1'b0;
      cmd.inc_idx = 1'b0;
      state_nxt   = S_AD_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      del_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del_r   <= del_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dteq_addsh.sv
// Add-path shift sequencer: writes a held entry one place up and steps the index down.
`timescale 1ns / 1ps
`default_nettype none
module dteq_addsh
  import dteq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  ctl_cmd_t  cmd_in,
  input  ctl_sts_t  sts,
  input  wire logic add_shift,
  output ctl_cmd_t  cmd_out
);

  logic chk_r;
  logic pend_r;

  // The read at index-1 lands in the check cycle. When that entry is later than the
  // new deadline, it is held and written at index in the cycle after, and the index steps down.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      chk_r  <= add_shift && (sts.command == CMD_ADD);
      pend_r <= chk_r && !sts.rd_le_new;
    end
  end

  always_comb begin
    cmd_out = cmd_in;
    if (pend_r) begin
      cmd_out.wr_hold = 1'b1;
      cmd_out.dec_idx = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/deadline_timer_event_queue.sv
// Top level of the deadline timer event queue.
//
//   channel | ports                               | handshake
//   input   | start, busy, in_word                | taken when start & !busy
//   result  | out_valid, out_word                 | one cycle per word, no stall
//   config  | cfg_we, cfg_wdata                   | written when cfg_we
//
// Set, unset and unknown commands are answered from dispatch. Add walks the
// table from the top, moving one entry up per step; delete scans the entries
// by id and shifts those above the match down; a tick fires expired head
// entries, shifting the table down after each, and then checks the slot.
// Reset is synchronous; the table needs no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module deadline_timer_event_queue
  import dteq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  ctl_cmd_t cmd_fsm, cmd;
  ctl_sts_t sts;
  logic     add_shift;

  dteq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd_fsm)
  );

  // Add shifting: the read at index-1 issued in the add read state.
  assign add_shift = cmd_fsm.rd_idx_m1;

  dteq_addsh u_addsh (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_in    (cmd_fsm),
    .sts       (sts),
    .add_shift (add_shift),
    .cmd_out   (cmd)
  );

  dteq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// File: rtl/dteq_checker.sv
// Port-level checker for the timer event queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dteq_checker
  import dteq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input out_word_t out_word
);

  // A word is taken only when the block was idle, so busy rises after it.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after start");

  // Results appear only while a word is in work.
  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result outside of work");

  // The last result ends the word: the block goes idle soon after.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |=> !out_valid) else $error("result after last");

  // Tick results other than done are never marked last.
  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == KIND_EVT || out_word.kind == KIND_SLOT)
    |-> !out_word.last) else $error("fired event marked last");

endmodule

bind deadline_timer_event_queue dteq_checker u_dteq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the deadline timer event queue.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import dteq_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   ident;
  } timer_entry_t;

  // One row of the directed table; has_word marks a typed-in single result.
  typedef struct {
    in_word_t  word;
    bit        has_word;
    out_word_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_word = '0;
  logic out_valid;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Predictor state.
  logic [TIME_W-1:0] now_us;
  timer_entry_t      pending[$];
  logic [ID_W-1:0]   next_ident;
  logic [TIME_W-1:0] slot_deadline;
  logic [TAG_W-1:0]  slot_tag;
  logic              slot_armed;
  logic [15:0]       tick_period;

  out_word_t expected_words[$];
  logic [ID_W-1:0] issued_ids[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  deadline_timer_event_queue uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t make_word(logic [2:0] kind, logic [ID_W-1:0] id,
                                          logic [TAG_W-1:0] tag, logic ok, logic last);
    out_word_t w;
    w.kind = kind; w.result_id = id; w.result_tag = tag; w.ok = ok; w.last = last;
    return w;
  endfunction

  // Advance the queue model by one command word and queue its results.
  task automatic predict_queue(in_word_t w);
    timer_entry_t e;
    int pos;
    int idx;
    bit found;
    bit stored;
    case (w.command)
      CMD_TICK: begin
        now_us = now_us + tick_period;
        while (pending.size() > 0 && pending[0].deadline <= now_us) begin
          expected_words.push_back(make_word(KIND_EVT, pending[0].ident, pending[0].tag,
                                             1'b1, 1'b0));
          void'(pending.pop_front());
        end
        if (slot_armed && slot_deadline <= now_us) begin
          slot_armed = 1'b0;
          expected_words.push_back(make_word(KIND_SLOT, '0, slot_tag, 1'b1, 1'b0));
        end
        expected_words.push_back(make_word(KIND_DONE, '0, '0, 1'b1, 1'b1));
      end
      CMD_ADD: begin
        e.deadline = now_us + w.delay_us;
        e.tag = w.event_tag;
        e.ident = next_ident;
        stored = 1'b0;
        if (pending.size() < DEPTH) begin
          pos = 0;
          while (pos < pending.size() && pending[pos].deadline <= e.deadline) pos++;
          pending.insert(pos, e);
          stored = 1'b1;
        end
        expected_words.push_back(make_word(KIND_ADD, next_ident, '0, stored, 1'b1));
        issued_ids.push_back(next_ident);
        next_ident = next_ident + 1'b1;
      end
      CMD_DEL: begin
        found = 0;
        idx = -1;
        foreach (pending[i]) if (idx < 0 && pending[i].ident == w.event_id) idx = i;
        if (idx >= 0) begin
          pending.delete(idx);
          found = 1;
        end
        expected_words.push_back(make_word(KIND_DEL, w.event_id, '0, found, 1'b1));
      end
      CMD_SET: begin
        slot_deadline = now_us + w.delay_us;
        slot_tag = w.event_tag;
        slot_armed = 1'b1;
        expected_words.push_back(make_word(KIND_DONE, '0, '0, 1'b1, 1'b1));
      end
      CMD_UNSET: begin
        slot_armed = 1'b0;
        expected_words.push_back(make_word(KIND_DONE, '0, '0, 1'b1, 1'b1));
      end
      default: expected_words.push_back(make_word(KIND_DONE, '0, '0, 1'b0, 1'b1));
    endcase
  endtask

  // Compare every result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_word);
        error_count++;
      end else begin
        if (out_word.kind !== expected_words[0].kind)
          $display("%0t: kind expected %0d actual %0d", $time,
                   expected_words[0].kind, out_word.kind);
        if (out_word.result_id !== expected_words[0].result_id)
          $display("%0t: id expected %0h actual %0h", $time,
                   expected_words[0].result_id, out_word.result_id);
        if (out_word.result_tag !== expected_words[0].result_tag)
          $display("%0t: tag expected %0h actual %0h", $time,
                   expected_words[0].result_tag, out_word.result_tag);
        if (out_word.ok !== expected_words[0].ok)
          $display("%0t: ok expected %0b actual %0b", $time,
                   expected_words[0].ok, out_word.ok);
        if (out_word.last !== expected_words[0].last)
          $display("%0t: last expected %0b actual %0b", $time,
                   expected_words[0].last, out_word.last);
        if (out_word !== expected_words[0]) error_count++;
        void'(expected_words.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted word or result.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[deadline_timer_event_queue] ERROR");
      $finish;
    end
  end

  // Present one command word and wait until it is taken.
  task automatic send_command(in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end else begin
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue(w);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_period = value;
  endtask

  function automatic in_word_t pick_command(bit wellformed);
    in_word_t w;
    int r;
    w.delay_us = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6000);
    w.event_tag = $urandom;
    w.event_id = 31'($urandom);
    if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0)
      w.event_id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
    r = $urandom_range(0, 99);
    if (!wellformed) w.command = 3'($urandom_range(0, 7));
    else if (r < 40) w.command = CMD_ADD;
    else if (r < 70) w.command = CMD_TICK;
    else if (r < 82) w.command = CMD_DEL;
    else if (r < 92) w.command = CMD_SET;
    else w.command = CMD_UNSET;
    return w;
  endfunction

  directed_row_t directed_rows[$];

  function automatic directed_row_t row(logic [2:0] cmd, logic [31:0] delay,
                                        logic [31:0] tag, logic [30:0] id,
                                        bit typed, out_word_t result);
    directed_row_t d;
    d.word.command = cmd; d.word.delay_us = delay; d.word.event_tag = tag;
    d.word.event_id = id; d.has_word = typed; d.result = result;
    return d;
  endfunction

  initial begin
    in_word_t w;
    int n;
    now_us = '0; next_ident = '0; slot_deadline = '0; slot_tag = '0;
    slot_armed = 1'b0; tick_period = TICK_PERIOD_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes, every command, ties, unknown codes, long delays.
    directed_rows.push_back(row(CMD_TICK, 0, 0, 0, 1, make_word(KIND_DONE, 0, 0, 1, 1)));
    directed_rows.push_back(row(CMD_ADD, 0, 32'hFFFF_FFFF, 0, 1,
                                make_word(KIND_ADD, 0, 0, 1, 1)));
    directed_rows.push_back(row(CMD_DEL, 0, 0, 31'h7FFF_FFFF, 1,
                                make_word(KIND_DEL, 31'h7FFF_FFFF, 0, 0, 1)));
    directed_rows.push_back(row(CMD_ADD, 500, 32'h1111, 0, 0, '0));
    directed_rows.push_back(row(CMD_ADD, 500, 32'h2222, 0, 0, '0));
    directed_rows.push_back(row(CMD_ADD, 32'hFFFF_FFFF, 32'h3333, 0, 0, '0));
    directed_rows.push_back(row(CMD_ADD, 200, 32'h4444, 0, 0, '0));
    directed_rows.push_back(row(CMD_SET, 900, 32'hABCD, 0, 1, make_word(KIND_DONE, 0, 0, 1, 1)));
    directed_rows.push_back(row(CMD_SET, 1500, 32'hFFFF_FFFF, 0, 1,
                                make_word(KIND_DONE, 0, 0, 1, 1)));
    directed_rows.push_back(row(CMD_TICK, 0, 0, 0, 0, '0));
    directed_rows.push_back(row(CMD_DEL, 0, 0, 5, 0, '0));
    directed_rows.push_back(row(CMD_DEL, 0, 0, 3, 0, '0));
    directed_rows.push_back(row(CMD_TICK, 0, 0, 0, 0, '0));
    directed_rows.push_back(row(CMD_UNSET, 0, 0, 0, 1, make_word(KIND_DONE, 0, 0, 1, 1)));
    directed_rows.push_back(row(CMD_UNSET, 0, 0, 0, 1, make_word(KIND_DONE, 0, 0, 1, 1)));
    directed_rows.push_back(row(3'd5, 0, 0, 0, 1, make_word(KIND_DONE, 0, 0, 0, 1)));
    directed_rows.push_back(row(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1,
                                make_word(KIND_DONE, 0, 0, 0, 1)));
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].word);
      if (directed_rows[i].has_word && expected_words[$] !== directed_rows[i].result) begin
        $display("%0t: table row %0d expected %h predicted %h", $time, i,
                 directed_rows[i].result, expected_words[$]);
        error_count++;
      end
    end

    // Fill the table past full, then drain it with a long period.
    wait_drained();
    write_period(16'hFFFF);
    for (int i = 0; i < DEPTH + 2; i++) begin
      w = pick_command(1);
      w.command = CMD_ADD;
      w.delay_us = $urandom_range(0, 200000);
      send_command(w);
    end
    repeat (4) begin
      w = '0;
      send_command(w);
    end

    // Random phases across several tick periods, the extremes among them.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: write_period(16'd1);
        1: write_period(16'd0);
        2: write_period(16'($urandom_range(100, 3000)));
        default: write_period(TICK_PERIOD_RST);
      endcase
      n = 0;
      while (n < 25) begin
        quiet = (phase == 3 && n > 12);
        w = pick_command($urandom_range(0, 9) != 0);
        send_command(w);
        n++;
      end
    end
    quiet = 0;

    wait_drained();
    if (error_count == 0) begin
      $display("[deadline_timer_event_queue] OK");
    end else begin
      $display("[deadline_timer_event_queue] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
